/* design/mdvk_pkg.sv */
// ----------------------------------------------------------------------------
// mdvk_pkg
// Types, constants and the Morse element table for the vibration keyer.
// ----------------------------------------------------------------------------
package mdvk_pkg;

	typedef struct packed {
		logic [15:0] unit_ticks;
		logic        append_gap;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_code;
	} item_t;

	localparam logic        KIND_CHAR      = 1'b0;
	localparam logic        KIND_TICK      = 1'b1;

	localparam logic        REG_UNIT_TICKS = 1'b0;
	localparam logic        REG_APPEND_GAP = 1'b1;

	localparam logic [15:0] UNIT_TICKS_RST = 16'd100;
	localparam logic        APPEND_GAP_RST = 1'b1;

	localparam logic [3:0]  SYM_LAST_DIGIT = 4'd9;
	localparam logic [3:0]  SYM_SPACE      = 4'd10;
	localparam logic [3:0]  SYM_GAP        = 4'd11;
	localparam logic [3:0]  NUM_SYMBOLS    = 4'd12;

	localparam logic [7:0]  CH_ZERO        = 8'h30;
	localparam logic [7:0]  CH_NINE        = 8'h39;
	localparam logic [7:0]  CH_SPACE       = 8'h20;
	localparam logic [7:0]  CH_PLUS        = 8'h2B;

	localparam logic [1:0]  UNITS_DOT      = 2'd1;
	localparam logic [1:0]  UNITS_DASH     = 2'd3;
	localparam logic [1:0]  UNITS_OFF      = 2'd0;

	// number of table entries played for a symbol
	function automatic logic [3:0] symbol_length(input logic [3:0] sel);
		logic [3:0] len;
		if (sel <= SYM_LAST_DIGIT) begin
			len = 4'd9;
		end else if (sel == SYM_SPACE) begin
			len = 4'd1;
		end else if (sel == SYM_GAP) begin
			len = 4'd3;
		end else begin
			len = 4'd0;
		end
		return len;
	endfunction

	// on-units of an entry; odd entries are the inter-element gaps
	function automatic logic [1:0] elem_value(input logic [3:0] sel, input logic [3:0] idx);
		logic [3:0] k;
		logic       dot;
		logic [1:0] v;
		k   = {1'b0, idx[3:1]};
		dot = 1'b0;
		if ((sel >= 4'd1) && (sel <= 4'd5) && (k < sel)) begin
			dot = 1'b1;
		end
		if ((sel >= 4'd6) && (sel <= SYM_LAST_DIGIT) && (k >= (sel - 4'd5))) begin
			dot = 1'b1;
		end
		if ((sel > SYM_LAST_DIGIT) || (idx > 4'd8) || idx[0]) begin
			v = UNITS_OFF;
		end else if (dot) begin
			v = UNITS_DOT;
		end else begin
			v = UNITS_DASH;
		end
		return v;
	endfunction

endpackage

/* design/mdvk_cfg.sv */
// ----------------------------------------------------------------------------
// mdvk_cfg
// APB register block: unit length in ticks and the trailing-gap enable.
// ----------------------------------------------------------------------------
module mdvk_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output mdvk_pkg::cfg_t cfg
);

	logic [15:0] unit_ticks_q;
	logic        append_gap_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= mdvk_pkg::UNIT_TICKS_RST;
			append_gap_q <= mdvk_pkg::APPEND_GAP_RST;
		end else if (wr_en) begin
			case (paddr[2])
				mdvk_pkg::REG_UNIT_TICKS: unit_ticks_q <= pwdata[15:0];
				mdvk_pkg::REG_APPEND_GAP: append_gap_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mdvk_pkg::REG_UNIT_TICKS: prdata = {16'd0, unit_ticks_q};
			mdvk_pkg::REG_APPEND_GAP: prdata = {31'd0, append_gap_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg.unit_ticks = unit_ticks_q;
	assign cfg.append_gap = append_gap_q;

endmodule

/* design/mdvk_in_stage.sv */
// ----------------------------------------------------------------------------
// mdvk_in_stage
// Input register: captures one item whenever it is empty or draining.
// ----------------------------------------------------------------------------
module mdvk_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	input  logic [7:0]      char_code,
	input  logic            adv,
	output logic            valid_s1,
	output mdvk_pkg::item_t item_s1
);

	logic load;

	assign load     = !valid_s1 || adv;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1.kind      <= kind;
			item_s1.char_code <= char_code;
		end
	end

endmodule

/* design/mdvk_core.sv */
// ----------------------------------------------------------------------------
// mdvk_core
// Keyer state, single-pass next-state logic and the result register.
// ----------------------------------------------------------------------------
module mdvk_core (
	input  logic            clk,
	input  logic            arst_n,
	input  mdvk_pkg::cfg_t  cfg,
	input  logic            valid_s1,
	input  mdvk_pkg::item_t item_s1,
	output logic            adv,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            motor_on,
	output logic            ready_res,
	output logic            rejected
);

	logic [3:0]  sel_q, idx_q;
	logic [1:0]  units_q;
	logic [15:0] tick_q;
	logic        gap_q, motor_q, busy_q;

	logic [3:0]  sel_d, idx_d;
	logic [1:0]  units_d;
	logic [15:0] tick_d;
	logic        gap_d, motor_d, busy_d, rej_d;

	logic        out_valid_q, motor_on_q, ready_q, rej_q;
	logic        fire;

	logic [15:0] unit;
	logic [16:0] cnt;
	logic        unit_done;
	logic [1:0]  units_dec;
	logic [3:0]  idx_inc;
	logic        load_en;
	logic [3:0]  load_sel, load_idx;
	logic [1:0]  load_v;
	logic        go_idle;

	assign adv  = !out_valid_q || !out_stall;
	assign fire = valid_s1 && adv;

	assign unit      = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
	assign cnt       = {1'b0, tick_q} + 17'd1;
	assign unit_done = cnt >= {1'b0, unit};
	assign units_dec = units_q - 2'd1;
	assign idx_inc   = idx_q + 4'd1;

	always_comb begin
		sel_d    = sel_q;
		idx_d    = idx_q;
		units_d  = units_q;
		tick_d   = tick_q;
		gap_d    = gap_q;
		motor_d  = motor_q;
		busy_d   = busy_q;
		rej_d    = 1'b0;
		load_en  = 1'b0;
		load_sel = sel_q;
		load_idx = 4'd0;
		load_v   = mdvk_pkg::UNITS_OFF;
		go_idle  = 1'b0;

		if (item_s1.kind == mdvk_pkg::KIND_CHAR) begin
			if (busy_q) begin
				rej_d = 1'b1;
			end else if ((item_s1.char_code >= mdvk_pkg::CH_ZERO) &&
			             (item_s1.char_code <= mdvk_pkg::CH_NINE)) begin
				load_en  = 1'b1;
				load_sel = 4'(item_s1.char_code - mdvk_pkg::CH_ZERO);
				gap_d    = cfg.append_gap;
			end else if (item_s1.char_code == mdvk_pkg::CH_SPACE) begin
				load_en  = 1'b1;
				load_sel = mdvk_pkg::SYM_SPACE;
				gap_d    = cfg.append_gap;
			end else if (item_s1.char_code == mdvk_pkg::CH_PLUS) begin
				load_en  = 1'b1;
				load_sel = mdvk_pkg::SYM_GAP;
				gap_d    = cfg.append_gap;
			end else if (cfg.append_gap) begin
				load_en  = 1'b1;
				load_sel = mdvk_pkg::SYM_GAP;
				gap_d    = 1'b0;
			end
			busy_d = busy_q | load_en;
		end else if (busy_q) begin
			if (sel_q >= mdvk_pkg::NUM_SYMBOLS) begin
				go_idle = 1'b1;
			end else if (unit_done) begin
				tick_d  = 16'd0;
				units_d = units_dec;
				if (units_dec == 2'd0) begin
					if (idx_inc < mdvk_pkg::symbol_length(sel_q)) begin
						load_en  = 1'b1;
						load_sel = sel_q;
						load_idx = idx_inc;
					end else if (gap_q) begin
						load_en  = 1'b1;
						load_sel = mdvk_pkg::SYM_GAP;
						gap_d    = 1'b0;
					end else begin
						idx_d   = idx_inc;
						go_idle = 1'b1;
					end
				end
			end else begin
				tick_d = cnt[15:0];
			end
		end

		if (load_en) begin
			load_v  = mdvk_pkg::elem_value(load_sel, load_idx);
			sel_d   = load_sel;
			idx_d   = load_idx;
			motor_d = (load_v != mdvk_pkg::UNITS_OFF);
			units_d = (load_v != mdvk_pkg::UNITS_OFF) ? load_v : mdvk_pkg::UNITS_DOT;
			tick_d  = 16'd0;
		end
		if (go_idle) begin
			busy_d  = 1'b0;
			motor_d = 1'b0;
			idx_d   = 4'd0;
			units_d = 2'd0;
			tick_d  = 16'd0;
			gap_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 4'd0;
			idx_q       <= 4'd0;
			units_q     <= 2'd0;
			tick_q      <= 16'd0;
			gap_q       <= 1'b0;
			motor_q     <= 1'b0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				sel_q   <= sel_d;
				idx_q   <= idx_d;
				units_q <= units_d;
				tick_q  <= tick_d;
				gap_q   <= gap_d;
				motor_q <= motor_d;
				busy_q  <= busy_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			motor_on_q <= motor_d;
			ready_q    <= !busy_d;
			rej_q      <= rej_d;
		end
	end

	assign out_valid = out_valid_q;
	assign motor_on  = motor_on_q;
	assign ready_res = ready_q;
	assign rejected  = rej_q;

`ifndef SYNTHESIS
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rej_q) |-> !ready_q)
		else $error("rejected item reported as ready");
	a_idle_off: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !motor_q)
		else $error("motor driven while idle");
	a_units_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (units_q != 2'd0))
		else $error("busy with no units left");
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (item_s1.kind == mdvk_pkg::KIND_TICK) && !busy_q) |=> !busy_q)
		else $error("tick started a character");
`endif

endmodule

/* design/morse_digit_vibration_keyer_top.sv */
// ----------------------------------------------------------------------------
// morse_digit_vibration_keyer_top
// Morse keyer for a vibration motor: digits, space and '+' to on/off drive.
// ----------------------------------------------------------------------------
// Every item (a character or one tick) gives exactly one result, which reaches
// the output port once the item has passed from the input register through the
// keyer logic into the result register. One item is taken per cycle; the input
// stalls only while both registers are full and the result is stalled.
// unit_ticks and append_gap sit at byte addresses 0 and 4 and should be
// written only while no item is in flight.
module morse_digit_vibration_keyer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        motor_on,
	output logic        ready_res,
	output logic        rejected,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mdvk_pkg::cfg_t  cfg;
	mdvk_pkg::item_t item_s1;
	logic            valid_s1;
	logic            adv;

	mdvk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mdvk_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.char_code (char_code),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	mdvk_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.motor_on  (motor_on),
		.ready_res (ready_res),
		.rejected  (rejected)
	);

endmodule
